// ===== src/dtvw_pkg.sv =====
// Shared types, constants and table functions for the date and time checker.
// No dependencies; imported by dtvw_front and date_time_validate_weekday_top.
`timescale 1ns / 1ps

package dtvw_pkg;

	localparam logic [13:0] YEAR_LO   = 14'd2000;
	localparam logic [13:0] YEAR_HI   = 14'd2099;
	localparam logic [3:0]  MONTH_JAN = 4'd1;
	localparam logic [3:0]  MONTH_FEB = 4'd2;
	localparam logic [3:0]  MONTH_MAR = 4'd3;
	localparam logic [3:0]  MONTH_DEC = 4'd12;
	localparam logic [4:0]  HOUR_MAX  = 5'd23;
	localparam logic [5:0]  MIN_MAX   = 6'd59;
	localparam logic [5:0]  SEC_MAX   = 6'd59;
	localparam logic [4:0]  FEB_LEAP  = 5'd29;
	localparam logic [2:0]  SUNDAY    = 3'd7;
	// Weekday term of the year before 2000, from the Sakamoto year sum.
	localparam logic [2:0]  PRE_CENTURY_TERM = 3'd5;
	localparam logic [3:0]  MOD7 = 4'd7;

	// Decoded first-stage fields handed from the front end to the pipeline.
	typedef struct packed {
		logic       ok;      // clock, year, month and time all in range
		logic [6:0] yic;     // year within the century
		logic [4:0] len;     // month length, zero for a bad month
		logic [4:0] day;
		logic [2:0] moff;    // Sakamoto month offset
		logic [6:0] kk;      // shifted year within the century
		logic       wrap;    // shifted year falls in the previous century
	} front_t;

	// Days in a month for a non-leap year; zero for a month code outside 1..12.
	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] r;
		case (m)
			4'd1:    r = 5'd31;
			4'd2:    r = 5'd28;
			4'd3:    r = 5'd31;
			4'd4:    r = 5'd30;
			4'd5:    r = 5'd31;
			4'd6:    r = 5'd30;
			4'd7:    r = 5'd31;
			4'd8:    r = 5'd31;
			4'd9:    r = 5'd30;
			4'd10:   r = 5'd31;
			4'd11:   r = 5'd30;
			4'd12:   r = 5'd31;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Sakamoto month offsets.
	function automatic logic [2:0] month_off(input logic [3:0] m);
		logic [2:0] r;
		case (m)
			4'd1:    r = 3'd0;
			4'd2:    r = 3'd3;
			4'd3:    r = 3'd2;
			4'd4:    r = 3'd5;
			4'd5:    r = 3'd0;
			4'd6:    r = 3'd3;
			4'd7:    r = 3'd5;
			4'd8:    r = 3'd1;
			4'd9:    r = 3'd4;
			4'd10:   r = 3'd6;
			4'd11:   r = 3'd2;
			4'd12:   r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// Remainder by seven of an 8-bit value; eight is one modulo seven, so
	// the octal digits are folded twice and a final subtract corrects.
	function automatic logic [2:0] mod7(input logic [7:0] v);
		logic [4:0] f1;
		logic [3:0] f2;
		logic [3:0] r;
		f1 = {2'b00, v[7:6] == 2'b00 ? 3'd0 : {1'b0, v[7:6]}} + {2'b00, v[5:3]}
			+ {2'b00, v[2:0]};
		f2 = {2'b00, f1[4:3]} + {1'b0, f1[2:0]};
		r  = (f2 >= MOD7) ? f2 - MOD7 : f2;
		return r[2:0];
	endfunction

endpackage

// ===== src/date_time_validate_weekday_top.sv =====
// Top level of the date and time checker: three-stage pipeline whose last stage is the output register.
// Depends on dtvw_pkg and dtvw_front.
// Order: an accepted date is registered in stage 1, then stage 2, then stage 3,
// and res_valid is the stage-3 valid bit.
// Throughput: one date per cycle unless res_ready stalls the output; the three register stages each hold one item.
// Reset: arst_n clears the stage valid bits and clock_ready, which comes up at zero.
`timescale 1ns / 1ps

module date_time_validate_weekday_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clock_ready_we,
	input  logic        clock_ready_wdata,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [13:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  second,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        valid_res,
	output logic [2:0]  weekday,
	output logic [6:0]  year_in_century,
	output logic [4:0]  month_length
);
	import dtvw_pkg::*;

	logic        clock_ready_q;
	front_t      front;

	logic        v_s1, v_s2, v_s3;
	logic        adv1, adv2, adv3;

	logic        ok_s1;
	logic [6:0]  yic_s1;
	logic [4:0]  len_s1;
	logic [4:0]  day_s1;
	logic [2:0]  moff_s1;
	logic [6:0]  kk_s1;
	logic        wrap_s1;

	logic        ok_s2;
	logic [6:0]  yic_s2;
	logic [4:0]  len_s2;
	logic [7:0]  sum_s2;

	logic        ok_s3;
	logic [2:0]  wd_s3;
	logic [6:0]  yic_s3;
	logic [4:0]  len_s3;

	logic        day_ok;
	logic [7:0]  year_term;
	logic [7:0]  sum_next;
	logic [2:0]  rem;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_ready_q <= 1'b0;
		end else if (clock_ready_we) begin
			clock_ready_q <= clock_ready_wdata;
		end
	end

	// Stall control: a stage loads when it is empty or its content moves on.
	assign adv3      = !v_s3 || res_ready;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign req_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= req_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	dtvw_front u_front (
		.clock_ready (clock_ready_q),
		.year        (year),
		.month       (month),
		.day         (day),
		.hour        (hour),
		.minute      (minute),
		.second      (second),
		.front       (front)
	);

	// Stage 1: decoded fields.
	always_ff @(posedge clk) begin
		if (adv1) begin
			ok_s1   <= front.ok;
			yic_s1  <= front.yic;
			len_s1  <= front.len;
			day_s1  <= front.day;
			moff_s1 <= front.moff;
			kk_s1   <= front.kk;
			wrap_s1 <= front.wrap;
		end
	end

	// Stage 2: day check and the Sakamoto sum, using the pre-century term when the shifted year wraps.
	assign day_ok    = (day_s1 != 5'd0) && (day_s1 <= len_s1);
	assign year_term = wrap_s1 ? {5'd0, PRE_CENTURY_TERM}
		: {1'b0, kk_s1} + {3'd0, kk_s1[6:2]};
	assign sum_next  = year_term + {5'd0, moff_s1} + {3'd0, day_s1};

	always_ff @(posedge clk) begin
		if (adv2) begin
			ok_s2  <= ok_s1 && day_ok;
			yic_s2 <= yic_s1;
			len_s2 <= len_s1;
			sum_s2 <= sum_next;
		end
	end

	// Stage 3: weekday from the remainder, fields zeroed for a rejected item.
	assign rem = mod7(sum_s2);

	always_ff @(posedge clk) begin
		if (adv3) begin
			ok_s3  <= ok_s2;
			wd_s3  <= !ok_s2 ? 3'd0 : (rem == 3'd0 ? SUNDAY : rem);
			yic_s3 <= ok_s2 ? yic_s2 : 7'd0;
			len_s3 <= ok_s2 ? len_s2 : 5'd0;
		end
	end

	assign res_valid       = v_s3;
	assign valid_res       = ok_s3;
	assign weekday         = wd_s3;
	assign year_in_century = yic_s3;
	assign month_length    = len_s3;

`ifndef SYNTHESIS
	// A rejected result carries only zeros.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !valid_res |-> weekday == 3'd0 && year_in_century == 7'd0
			&& month_length == 5'd0)
		else $error("rejected result has nonzero fields");

	// An accepted result has a real weekday, year and month length.
	a_accept_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && valid_res |-> weekday != 3'd0 && year_in_century <= 7'd99
			&& month_length >= 5'd28)
		else $error("accepted result out of range");

	// A full pipeline with the output stalled takes no new item.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && !res_ready |-> !req_ready)
		else $error("input taken while pipeline is full");

	// A stalled result stays in place into the next cycle.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !res_ready |=> v_s3 && $stable(wd_s3) && $stable(ok_s3))
		else $error("stalled result changed");
`endif

endmodule

// ===== src/dtvw_front.sv =====
// First-stage decode: range checks, century offset, month length and Sakamoto terms.
// Depends on dtvw_pkg.
`timescale 1ns / 1ps

module dtvw_front (
	input  logic              clock_ready,
	input  logic [13:0]       year,
	input  logic [3:0]        month,
	input  logic [4:0]        day,
	input  logic [4:0]        hour,
	input  logic [5:0]        minute,
	input  logic [5:0]        second,
	output dtvw_pkg::front_t  front
);
	import dtvw_pkg::*;

	logic [13:0] diff;
	logic        year_ok;
	logic        month_ok;
	logic        time_ok;
	logic        leap;
	logic        early;

	// Range checks on year, month and time of day.
	assign diff     = year - YEAR_LO;
	assign year_ok  = (year >= YEAR_LO) && (year <= YEAR_HI);
	assign month_ok = (month >= MONTH_JAN) && (month <= MONTH_DEC);
	assign time_ok  = (hour <= HOUR_MAX) && (minute <= MIN_MAX) && (second <= SEC_MAX);

	// Within 2000..2099 the year 2000 divides by 400, so leap is a test by four.
	assign leap  = (diff[1:0] == 2'b00);
	assign early = (month < MONTH_MAR);

	always_comb begin
		front.ok   = clock_ready && year_ok && month_ok && time_ok;
		front.yic  = diff[6:0];
		front.len  = (month == MONTH_FEB && leap) ? FEB_LEAP : month_len(month);
		front.day  = day;
		front.moff = month_off(month);
		// January and February count against the previous year.
		front.wrap = early && (diff[6:0] == 7'd0);
		front.kk   = (early && !front.wrap) ? diff[6:0] - 7'd1 : diff[6:0];
	end

endmodule
